[design/cmm_pkg.sv]
package cmm_pkg;

   // sizes
   localparam int MAX_DIM      = 8;
   localparam int ELEM_BITS    = 16;
   localparam int IDX_BITS     = $clog2(MAX_DIM);
   localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
   localparam int PROD_BITS    = 2 * ELEM_BITS;
   localparam int WORD_BITS    = 2 * ELEM_BITS;

   // port field widths
   localparam int ACTION_BITS  = 2;
   localparam int POS_BITS     = 3;
   localparam int IN_PART_BITS = 16;
   localparam int ACC_BITS     = 36;
   localparam int DIM_BITS     = 4;
   localparam int CSR_IDX_BITS = 2;

   // queue depths
   localparam int CMD_DEPTH    = 4;
   localparam int OUT_DEPTH    = 4;

   localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(2);

   // request actions
   typedef enum logic [ACTION_BITS-1:0] {
      ACT_LOAD_A  = 2'd0,
      ACT_LOAD_B  = 2'd1,
      ACT_COMPUTE = 2'd2
   } action_type;

   // register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_A_ROWS = 2'd0,
      CSR_A_COLS = 2'd1,
      CSR_B_ROWS = 2'd2,
      CSR_B_COLS = 2'd3
   } csr_index_type;

   // classified command from front to back
   typedef enum logic [1:0] {
      CMD_LOAD_A,
      CMD_LOAD_B,
      CMD_COMPUTE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                kind;
      logic [ADDR_BITS-1:0]        addr;
      logic signed [ELEM_BITS-1:0] re;
      logic signed [ELEM_BITS-1:0] im;
   } cmd_type;

   // one product element
   typedef struct packed {
      logic [POS_BITS-1:0]        row;
      logic [POS_BITS-1:0]        col;
      logic signed [ACC_BITS-1:0] re;
      logic signed [ACC_BITS-1:0] im;
      logic                       is_last;
      logic                       nam;
   } result_type;

   // dimension register as used: zero counts as one, clamp at the maximum
   function automatic logic [DIM_BITS-1:0] used_dim(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (v > DIM_BITS'(MAX_DIM)) begin
         r = DIM_BITS'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

[design/cmm_ram.sv]
module cmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/cmm_front.sv]
module cmm_front
   import cmm_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [ACTION_BITS-1:0]         req_action,
   input  logic [POS_BITS-1:0]            req_elem_row,
   input  logic [POS_BITS-1:0]            req_elem_col,
   input  logic signed [IN_PART_BITS-1:0] req_elem_real,
   input  logic signed [IN_PART_BITS-1:0] req_elem_imag,
   output logic                           cmd_valid,
   output cmd_type                        cmd,
   input  logic                           cmd_pop
);

   localparam int PTR_BITS = $clog2(CMD_DEPTH);
   localparam int CNT_BITS = $clog2(CMD_DEPTH + 1);

   cmd_type             q_ff [CMD_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;

   cmd_type entry;
   logic    keep;
   logic    in_range;
   logic    push_ok;
   logic    pop_ok;

   // classify the request
   always_comb begin
      in_range   = (DIM_BITS'(req_elem_row) < DIM_BITS'(MAX_DIM)) &&
                   (DIM_BITS'(req_elem_col) < DIM_BITS'(MAX_DIM));
      entry.addr = ADDR_BITS'(req_elem_row * MAX_DIM + req_elem_col);
      entry.re   = ELEM_BITS'(req_elem_real);
      entry.im   = ELEM_BITS'(req_elem_imag);
      case (req_action)
         ACT_LOAD_A: begin
            entry.kind = CMD_LOAD_A;
            keep       = in_range;
         end
         ACT_LOAD_B: begin
            entry.kind = CMD_LOAD_B;
            keep       = in_range;
         end
         ACT_COMPUTE: begin
            entry.kind = CMD_COMPUTE;
            keep       = 1'b1;
         end
         default: begin
            entry.kind = CMD_COMPUTE;
            keep       = 1'b0;
         end
      endcase
   end

   assign req_full  = (count_ff == CNT_BITS'(CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full && keep;
   assign pop_ok    = cmd_pop && cmd_valid;

   // command queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   // command queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(CMD_DEPTH - 1)) ? '0 :
                         wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(CMD_DEPTH - 1)) ? '0 :
                         rd_ptr_ff + PTR_BITS'(1);
         end
         if (push_ok && !pop_ok) begin
            count_ff <= count_ff + CNT_BITS'(1);
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - CNT_BITS'(1);
         end
      end
   end

endmodule

[design/cmm_back.sv]
module cmm_back
   import cmm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_IDX_BITS-1:0]    csr_index,
   input  logic [DIM_BITS-1:0]        csr_wdata,
   input  logic                       cmd_valid,
   input  cmd_type                    cmd,
   output logic                       cmd_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [POS_BITS-1:0]        rsp_out_row,
   output logic [POS_BITS-1:0]        rsp_out_col,
   output logic signed [ACC_BITS-1:0] rsp_out_real,
   output logic signed [ACC_BITS-1:0] rsp_out_imag,
   output logic                       rsp_is_last,
   output logic                       rsp_not_a_matrix
);

   localparam int PTR_BITS = $clog2(OUT_DEPTH);
   localparam int CNT_BITS = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_NAM
   } state_type;

   typedef struct packed {
      logic                first;
      logic                last;
      logic                nam;
      logic                is_last;
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] col;
   } tok_type;

   state_type            state_ff;
   logic [IDX_BITS-1:0]  i_ff;
   logic [IDX_BITS-1:0]  j_ff;
   logic [IDX_BITS-1:0]  k_ff;
   logic [DIM_BITS-1:0]  a_rows_ff;
   logic [DIM_BITS-1:0]  a_cols_ff;
   logic [DIM_BITS-1:0]  b_rows_ff;
   logic [DIM_BITS-1:0]  b_cols_ff;

   logic                 s1_valid_ff;
   tok_type              s1_tok_ff;
   logic                 s2_valid_ff;
   tok_type              s2_tok_ff;
   logic signed [PROD_BITS-1:0] p_rr_ff;
   logic signed [PROD_BITS-1:0] p_ii_ff;
   logic signed [PROD_BITS-1:0] p_ri_ff;
   logic signed [PROD_BITS-1:0] p_ir_ff;
   logic signed [ACC_BITS-1:0]  acc_re_ff;
   logic signed [ACC_BITS-1:0]  acc_im_ff;

   result_type           out_q_ff [OUT_DEPTH];
   logic [PTR_BITS-1:0]  out_wr_ff;
   logic [PTR_BITS-1:0]  out_rd_ff;
   logic [CNT_BITS-1:0]  out_count_ff;
   logic [CNT_BITS-1:0]  pending_ff;

   logic [DIM_BITS-1:0]  ar;
   logic [DIM_BITS-1:0]  ac;
   logic [DIM_BITS-1:0]  br;
   logic [DIM_BITS-1:0]  bc;
   logic                 k_end;
   logic                 j_end;
   logic                 i_end;
   logic                 credit;
   logic                 issue;
   tok_type              tok;

   logic                 wr_a;
   logic                 wr_b;
   logic [WORD_BITS-1:0] wr_word;
   logic [ADDR_BITS-1:0] rd_addr_a;
   logic [ADDR_BITS-1:0] rd_addr_b;
   logic [WORD_BITS-1:0] rd_word_a;
   logic [WORD_BITS-1:0] rd_word_b;

   logic signed [ELEM_BITS-1:0] a_re;
   logic signed [ELEM_BITS-1:0] a_im;
   logic signed [ELEM_BITS-1:0] b_re;
   logic signed [ELEM_BITS-1:0] b_im;
   logic signed [ACC_BITS-1:0]  sum_re;
   logic signed [ACC_BITS-1:0]  sum_im;
   logic                        push;
   logic                        pop_ok;
   result_type                  res;
   result_type                  head;

   // dimensions as used
   assign ar = used_dim(a_rows_ff);
   assign ac = used_dim(a_cols_ff);
   assign br = used_dim(b_rows_ff);
   assign bc = used_dim(b_cols_ff);

   assign k_end = (DIM_BITS'(k_ff) == ac - DIM_BITS'(1));
   assign j_end = (DIM_BITS'(j_ff) == bc - DIM_BITS'(1));
   assign i_end = (DIM_BITS'(i_ff) == ar - DIM_BITS'(1));

   // an element may start only when its result has a guaranteed slot
   assign credit = ((CNT_BITS + 1)'(out_count_ff) + (CNT_BITS + 1)'(pending_ff)) <
                   (CNT_BITS + 1)'(OUT_DEPTH);

   assign issue = ((state_ff == ST_RUN) && ((k_ff != '0) || credit)) ||
                  ((state_ff == ST_NAM) && credit);

   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;

   // token for the element step being issued
   always_comb begin
      tok.nam     = (state_ff == ST_NAM);
      tok.first   = (k_ff == '0) || tok.nam;
      tok.last    = k_end || tok.nam;
      tok.is_last = (i_end && j_end) || tok.nam;
      tok.row     = POS_BITS'(i_ff);
      tok.col     = POS_BITS'(j_ff);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= DIM_RESET;
         a_cols_ff <= DIM_RESET;
         b_rows_ff <= DIM_RESET;
         b_cols_ff <= DIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_A_ROWS: a_rows_ff <= csr_wdata;
            CSR_A_COLS: a_cols_ff <= csr_wdata;
            CSR_B_ROWS: b_rows_ff <= csr_wdata;
            CSR_B_COLS: b_cols_ff <= csr_wdata;
            default:    a_rows_ff <= a_rows_ff;
         endcase
      end
   end

   // sequencer over rows, columns and the inner dimension
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid && (cmd.kind == CMD_COMPUTE)) begin
                  i_ff     <= '0;
                  j_ff     <= '0;
                  k_ff     <= '0;
                  state_ff <= (ac != br) ? ST_NAM : ST_RUN;
               end
            end
            ST_RUN: begin
               if (issue) begin
                  if (k_end) begin
                     k_ff <= '0;
                     if (j_end) begin
                        j_ff <= '0;
                        if (i_end) begin
                           state_ff <= ST_IDLE;
                        end else begin
                           i_ff <= i_ff + IDX_BITS'(1);
                        end
                     end else begin
                        j_ff <= j_ff + IDX_BITS'(1);
                     end
                  end else begin
                     k_ff <= k_ff + IDX_BITS'(1);
                  end
               end
            end
            ST_NAM: begin
               if (issue) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // element stores
   assign wr_a      = cmd_pop && (cmd.kind == CMD_LOAD_A);
   assign wr_b      = cmd_pop && (cmd.kind == CMD_LOAD_B);
   assign wr_word   = {cmd.re, cmd.im};
   assign rd_addr_a = ADDR_BITS'(i_ff * MAX_DIM + k_ff);
   assign rd_addr_b = ADDR_BITS'(k_ff * MAX_DIM + j_ff);

   cmm_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_left_store (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cmd.addr),
      .wr_data (wr_word),
      .rd_addr (rd_addr_a),
      .rd_data (rd_word_a)
   );

   cmm_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_right_store (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cmd.addr),
      .wr_data (wr_word),
      .rd_addr (rd_addr_b),
      .rd_data (rd_word_b)
   );

   assign a_re = rd_word_a[WORD_BITS-1:ELEM_BITS];
   assign a_im = rd_word_a[ELEM_BITS-1:0];
   assign b_re = rd_word_b[WORD_BITS-1:ELEM_BITS];
   assign b_im = rd_word_b[ELEM_BITS-1:0];

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // store read stage and product stage
   always_ff @(posedge clock) begin
      s1_tok_ff <= tok;
      s2_tok_ff <= s1_tok_ff;
      p_rr_ff   <= a_re * b_re;
      p_ii_ff   <= a_im * b_im;
      p_ri_ff   <= a_re * b_im;
      p_ir_ff   <= a_im * b_re;
   end

   // accumulate the dot product
   always_comb begin
      sum_re = (s2_tok_ff.first ? '0 : acc_re_ff) + ACC_BITS'(p_rr_ff) -
               ACC_BITS'(p_ii_ff);
      sum_im = (s2_tok_ff.first ? '0 : acc_im_ff) + ACC_BITS'(p_ri_ff) +
               ACC_BITS'(p_ir_ff);
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         acc_re_ff <= sum_re;
         acc_im_ff <= sum_im;
      end
   end

   // finished element
   assign push = s2_valid_ff && s2_tok_ff.last;

   always_comb begin
      if (s2_tok_ff.nam) begin
         res.row = '0;
         res.col = '0;
         res.re  = '0;
         res.im  = '0;
      end else begin
         res.row = s2_tok_ff.row;
         res.col = s2_tok_ff.col;
         res.re  = sum_re;
         res.im  = sum_im;
      end
      res.is_last = s2_tok_ff.is_last;
      res.nam     = s2_tok_ff.nam;
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         out_q_ff[out_wr_ff] <= res;
      end
   end

   assign pop_ok = rsp_pop && !rsp_empty;

   // result queue pointers and outstanding element count
   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
         pending_ff   <= '0;
      end else begin
         if (push) begin
            out_wr_ff <= (out_wr_ff == PTR_BITS'(OUT_DEPTH - 1)) ? '0 :
                         out_wr_ff + PTR_BITS'(1);
         end
         if (pop_ok) begin
            out_rd_ff <= (out_rd_ff == PTR_BITS'(OUT_DEPTH - 1)) ? '0 :
                         out_rd_ff + PTR_BITS'(1);
         end
         if (push && !pop_ok) begin
            out_count_ff <= out_count_ff + CNT_BITS'(1);
         end else if (pop_ok && !push) begin
            out_count_ff <= out_count_ff - CNT_BITS'(1);
         end
         if ((issue && tok.first) && !push) begin
            pending_ff <= pending_ff + CNT_BITS'(1);
         end else if (push && !(issue && tok.first)) begin
            pending_ff <= pending_ff - CNT_BITS'(1);
         end
      end
   end

   // oldest result on the ports
   assign head             = out_q_ff[out_rd_ff];
   assign rsp_empty        = (out_count_ff == '0);
   assign rsp_out_row      = head.row;
   assign rsp_out_col      = head.col;
   assign rsp_out_real     = head.re;
   assign rsp_out_imag     = head.im;
   assign rsp_is_last      = head.is_last;
   assign rsp_not_a_matrix = head.nam;

endmodule

[design/complex_matrix_multiply.sv]
// Complex matrix multiply engine.
// Requests enter through a queue-style port (req_push / req_full). A request
// loads one Q1.14 complex element into the left or right store, or asks for
// the product of the two matrices. Results leave through a second queue-style
// port (rsp_empty / rsp_pop): one Q7.28 complex element per product entry in
// row-major order, is_last on the final one, or a single not_a_matrix result
// when the inner dimensions disagree. Dimensions are set through the csr_
// write port; the user must do so only while the engine is idle, which the
// block itself does not enforce. Loads are taken one per cycle while the
// request queue has room, and reach the store once the engine is idle. A
// product request walks the stores over every row, column and inner index,
// one multiply-accumulate step per cycle unless paused, set by the single
// read port of each store. A four-entry request queue and a four-entry
// result queue sit on either side. When the receiver stalls the result queue
// fills and the walk pauses at the next element boundary; requests are still
// taken until the request queue fills. Reset empties both queues and sets
// every dimension to 2; store contents are undefined until loaded.
module complex_matrix_multiply
   import cmm_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [ACTION_BITS-1:0]         req_action,
   input  logic [POS_BITS-1:0]            req_elem_row,
   input  logic [POS_BITS-1:0]            req_elem_col,
   input  logic signed [IN_PART_BITS-1:0] req_elem_real,
   input  logic signed [IN_PART_BITS-1:0] req_elem_imag,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [POS_BITS-1:0]            rsp_out_row,
   output logic [POS_BITS-1:0]            rsp_out_col,
   output logic signed [ACC_BITS-1:0]     rsp_out_real,
   output logic signed [ACC_BITS-1:0]     rsp_out_imag,
   output logic                           rsp_is_last,
   output logic                           rsp_not_a_matrix,
   input  logic                           csr_we,
   input  logic [CSR_IDX_BITS-1:0]        csr_index,
   input  logic [DIM_BITS-1:0]            csr_wdata
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   // request intake and classification
   cmm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_action    (req_action),
      .req_elem_row  (req_elem_row),
      .req_elem_col  (req_elem_col),
      .req_elem_real (req_elem_real),
      .req_elem_imag (req_elem_imag),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   // stores, multiply-accumulate and result queue
   cmm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_out_real     (rsp_out_real),
      .rsp_out_imag     (rsp_out_imag),
      .rsp_is_last      (rsp_is_last),
      .rsp_not_a_matrix (rsp_not_a_matrix)
   );

endmodule

[design/cmm_checker.sv]
module cmm_checker
   import cmm_pkg::*;
(
   input logic                           clock,
   input logic                           reset,
   input logic                           req_full,
   input logic                           rsp_empty,
   input logic                           rsp_pop,
   input logic [POS_BITS-1:0]            rsp_out_row,
   input logic [POS_BITS-1:0]            rsp_out_col,
   input logic signed [ACC_BITS-1:0]     rsp_out_real,
   input logic signed [ACC_BITS-1:0]     rsp_out_imag,
   input logic                           rsp_is_last,
   input logic                           rsp_not_a_matrix
);

   // reset leaves no result waiting
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting after reset");

   // reset leaves room for requests
   a_reset_room: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request port full after reset");

   // an incompatible run gives a single zero result that closes the run
   a_nam_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_not_a_matrix) |->
         (rsp_is_last && (rsp_out_real == '0) && (rsp_out_imag == '0) &&
          (rsp_out_row == '0) && (rsp_out_col == '0)))
      else $error("malformed not-a-matrix result");

   // a result that is not the last of its run is followed within the run
   a_order: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_is_last && !rsp_not_a_matrix) |=>
         (rsp_empty || !rsp_not_a_matrix))
      else $error("not-a-matrix result inside a product run");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_real) && $stable(rsp_out_imag) &&
          $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_is_last)))
      else $error("waiting result changed");

endmodule

bind complex_matrix_multiply cmm_checker u_checker (.*);
